// File: design/tccs_pkg.sv
`default_nettype none
package tccs_pkg;

  // Command codes
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Control bytes interpreted by put
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [7:0]  BLANK_ATTR = 8'h07;
  localparam logic [15:0] BLANK_CELL = {BLANK_ATTR, CH_SPACE};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL
  } tccs_state_t;

  // Cursor after the request, plus what the request does to the screen
  typedef struct packed {
    logic [6:0] col;
    logic [4:0] row;
    logic       scroll;
    logic       store;
  } tccs_curs_t;

endpackage
`default_nettype wire

// File: design/tccs_ram.sv
`default_nettype none
module tccs_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [15:0]        rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: design/tccs_cursor.sv
`default_nettype none
module tccs_cursor #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8,
  parameter int AW       = 11
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic [1:0]    command,
  input  wire logic [7:0]    char_code,
  output tccs_pkg::tccs_curs_t curs,
  output logic [AW-1:0]      store_addr
);
  import tccs_pkg::*;

  localparam int MW = (TAB_STOP > 2) ? $clog2(TAB_STOP) : 1;

  logic [6:0]    col_r, col_nxt;
  logic [4:0]    row_r, row_nxt;
  // column modulo TAB_STOP, kept alongside the column
  logic [MW-1:0] mod_r, mod_nxt;
  logic          scroll;
  logic          store;
  logic [7:0]    col_inc;
  logic [7:0]    tab_col;
  logic [5:0]    row_inc;
  logic [MW-1:0] mod_inc;
  logic [MW-1:0] mod_dec;
  logic          wrap;

  always_comb begin
    col_inc = 8'(col_r) + 8'd1;
    tab_col = 8'(col_r) + (8'(TAB_STOP) - 8'(mod_r));
    row_inc = 6'(row_r) + 6'd1;
    mod_inc = (32'(mod_r) == TAB_STOP - 1) ? '0 : mod_r + MW'(1);
    mod_dec = (mod_r == '0) ? MW'(TAB_STOP - 1) : mod_r - MW'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    mod_nxt = mod_r;
    scroll  = 1'b0;
    store   = 1'b0;
    wrap    = 1'b0;
    unique case (command)
      CMD_PUT: begin
        case (char_code)
          CH_NEWLINE: wrap = 1'b1;
          CH_RETURN: begin
            col_nxt = '0;
            mod_nxt = '0;
          end
          CH_TAB: begin
            if (32'(tab_col) >= COLUMNS) begin
              wrap = 1'b1;
            end else begin
              col_nxt = tab_col[6:0];
              mod_nxt = '0;
            end
          end
          CH_BACKSPACE: begin
            if (col_r != '0) begin
              col_nxt = col_r - 7'd1;
              mod_nxt = mod_dec;
            end
          end
          default: begin
            store = 1'b1;
            if (32'(col_inc) >= COLUMNS) begin
              wrap = 1'b1;
            end else begin
              col_nxt = col_inc[6:0];
              mod_nxt = mod_inc;
            end
          end
        endcase
        if (wrap) begin
          col_nxt = '0;
          mod_nxt = '0;
          if (32'(row_inc) >= ROWS) begin
            row_nxt = 5'(ROWS - 1);
            scroll  = 1'b1;
          end else begin
            row_nxt = row_inc[4:0];
          end
        end
      end
      CMD_CLEAR: begin
        col_nxt = '0;
        row_nxt = '0;
        mod_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      mod_r <= '0;
    end else if (adv) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      mod_r <= mod_nxt;
    end
  end

  assign curs.col    = col_nxt;
  assign curs.row    = row_nxt;
  assign curs.scroll = scroll;
  assign curs.store  = store;
  assign store_addr  = AW'(32'(row_r) * COLUMNS + 32'(col_r));

endmodule
`default_nettype wire

// File: design/text_console_cursor_scroll_top.sv
`default_nettype none
// Text-mode console: a ROWS x COLUMNS screen of 16-bit cells (attribute high byte,
// character low byte) held in one single-port-write, registered-read memory, plus
// a cursor. Every request returns one result with the cursor after the request.
// After reset the block blanks all ROWS*COLUMNS cells (2000 by default) with
// attribute 0x07 while in_ready is low. Puts of printable or control bytes that do
// not scroll, and ignored commands, register their result directly; a cell read
// passes through the READ state for the registered memory read. Clear writes
// every cell with the given attribute and a space, and a put that scrolls copies
// each cell up one row and then blanks the bottom row with attribute 0x07, all
// through the single memory write port. One request is in flight at a time; a new
// one is taken while the previous result is being handed off.
module text_console_cursor_scroll_top #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [7:0]  in_attribute,
  input  wire logic [10:0] in_cell_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_cell_value,
  output logic [6:0]       out_cursor_column,
  output logic [4:0]       out_cursor_row,
  output logic             out_scrolled
);
  import tccs_pkg::*;

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam logic [AW-1:0] LAST_COPY  = AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [AW-1:0] BOTTOM_ROW = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELL_COUNT - 1);

  tccs_state_t   state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] dst_r, dst_nxt;
  logic          wr_pend_r, wr_pend_nxt;
  logic          res_pend_r, res_pend_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [15:0]   fill_r, fill_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_cell_r, out_cell_nxt;
  logic [6:0]    out_col_r, out_col_nxt;
  logic [4:0]    out_row_r, out_row_nxt;
  logic          out_scr_r, out_scr_nxt;

  logic          accept;
  logic          adv;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [AW-1:0] raddr;
  logic [15:0]   rdata;
  logic [AW-1:0] store_addr;
  tccs_curs_t    curs;

  tccs_cursor #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP),
    .AW       (AW)
  ) u_cursor (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .command    (in_command),
    .char_code  (in_char_code),
    .curs       (curs),
    .store_addr (store_addr)
  );

  tccs_ram #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    dst_nxt       = dst_r;
    wr_pend_nxt   = wr_pend_r;
    res_pend_nxt  = res_pend_r;
    rd_ok_nxt     = rd_ok_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_cell_nxt  = out_cell_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_scr_nxt   = out_scr_r;
    adv           = 1'b0;
    we            = 1'b0;
    waddr         = cnt_r;
    wdata         = fill_r;
    raddr         = AW'(in_cell_address);
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          adv          = 1'b1;
          out_cell_nxt = '0;
          out_col_nxt  = curs.col;
          out_row_nxt  = curs.row;
          out_scr_nxt  = curs.scroll;
          rd_ok_nxt    = 32'(in_cell_address) < CELL_COUNT;
          unique case (in_command)
            CMD_PUT: begin
              if (curs.store) begin
                we    = 1'b1;
                waddr = store_addr;
                wdata = {in_attribute, in_char_code};
              end
              if (curs.scroll) begin
                state_nxt    = ST_COPY;
                cnt_nxt      = '0;
                wr_pend_nxt  = 1'b0;
                res_pend_nxt = 1'b1;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            CMD_CLEAR: begin
              state_nxt    = ST_FILL;
              cnt_nxt      = '0;
              wr_pend_nxt  = 1'b0;
              fill_nxt     = {in_attribute, CH_SPACE};
              res_pend_nxt = 1'b1;
            end
            CMD_READ: state_nxt = ST_READ;
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        out_cell_nxt  = rd_ok_r ? rdata : '0;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_COPY: begin
        // read one row below, write back the cell read last cycle
        raddr       = AW'(32'(cnt_r) + COLUMNS);
        we          = wr_pend_r;
        waddr       = dst_r;
        wdata       = rdata;
        dst_nxt     = cnt_r;
        wr_pend_nxt = 1'b1;
        if (cnt_r == LAST_COPY) begin
          state_nxt = ST_FILL;
          fill_nxt  = BLANK_CELL;
          cnt_nxt   = BOTTOM_ROW;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_FILL: begin
        we = 1'b1;
        if (wr_pend_r) begin
          // drain the last copy write before filling
          waddr       = dst_r;
          wdata       = rdata;
          wr_pend_nxt = 1'b0;
        end else if (cnt_r == LAST_CELL) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = res_pend_r;
          res_pend_nxt  = 1'b0;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cnt_r       <= '0;
      wr_pend_r   <= 1'b0;
      res_pend_r  <= 1'b0;
      fill_r      <= BLANK_CELL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wr_pend_r   <= wr_pend_nxt;
      res_pend_r  <= res_pend_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_r      <= dst_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_cell_r <= out_cell_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_cell_value    = out_cell_r;
  assign out_cursor_column = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_scrolled      = out_scr_r;

endmodule
`default_nettype wire
